// ===== sv/earliest_free_server_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the earliest free server queue
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef EARLIEST_FREE_SERVER_QUEUE_TOP_MACROS_SVH
`define EARLIEST_FREE_SERVER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication.
`define EFSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EFSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/efsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsq_pkg
// Field widths, register indexes and stream payload layouts of the earliest
// free server queue.
// ----------------------------------------------------------------------------
package efsq_pkg;

  localparam int unsigned ARRIVAL_W = 24;
  localparam int unsigned SERVICE_W = 24;
  localparam int unsigned WAIT_W    = 24;
  localparam int unsigned SERVER_W  = 3;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned ACTIVE_W  = 4;
  localparam int unsigned LIMIT_W   = 24;

  localparam int unsigned IN_TDATA_W   = ARRIVAL_W + SERVICE_W;
  localparam int unsigned OUT_FIELDS_W = WAIT_W + SERVER_W + SUM_W + 2 * CNT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = ACTIVE_W'(1);
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgActiveServers,
    CfgLongWaitLimit
  } cfg_idx_e;

  typedef struct packed {
    logic [SERVICE_W-1:0] service_time;
    logic [ARRIVAL_W-1:0] arrival_time;
  } in_tdata_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [CNT_W-1:0]     jobs_seen;
    logic [CNT_W-1:0]     long_wait_jobs;
    logic [SUM_W-1:0]     total_wait;
    logic [SERVER_W-1:0]  chosen_server;
    logic [WAIT_W-1:0]    job_wait;
  } out_tdata_t;

endpackage

// ===== sv/earliest_free_server_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_server_queue_top
// Takes one job request at a time, gives it to the active server that is
// free earliest (lowest index on ties) and returns the wait, the server and
// saturating running totals. start_batch clears free times and totals first.
// The free times of the active servers (active_servers clamped to
// 1..MAX_SERVERS) sit in one single-port memory with a registered read,
// which is scanned one server per cycle, followed by a drain state, an
// update and write-back state and a totals state that loads the result;
// the next request is taken in the idle state that follows. Results wait in
// an output register; a stalled output holds the block in the totals state.
// Configuration writes are taken in any cycle and must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module earliest_free_server_queue_top #(
  parameter int unsigned MAX_SERVERS = 8,
  parameter int unsigned TIME_BITS   = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // arrival_time [23:0], service_time [47:24]
  input  logic [efsq_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // start_batch
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // job_wait [23:0], chosen_server [26:24], total_wait [66:27],
  // long_wait_jobs [82:67], jobs_seen [98:83], zero [103:99]
  output logic [efsq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [efsq_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [efsq_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import efsq_pkg::*;

  localparam int unsigned IW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int unsigned CW = $clog2(MAX_SERVERS + 1);
  localparam int unsigned EW = (CW > ACTIVE_W) ? CW : ACTIVE_W;
  localparam int unsigned XW = (TIME_BITS > WAIT_W) ? TIME_BITS : WAIT_W;
  localparam int unsigned AW = ((TIME_BITS > SUM_W) ? TIME_BITS : SUM_W) + 1;

  localparam logic [XW-1:0] TIME_MAX_X = XW'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [XW-1:0] WAIT_MAX_X = XW'({WAIT_W{1'b1}});
  localparam logic [AW-1:0] SUM_MAX_X  = AW'({SUM_W{1'b1}});
  localparam logic [EW-1:0] MAX_SRV_X  = EW'(MAX_SERVERS);

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StDrain,
    StUpdate,
    StDone
  } state_e;

  state_e                 state_q;
  logic [MAX_SERVERS-1:0] valid_q;
  logic [ACTIVE_W-1:0]    active_q;
  logic [LIMIT_W-1:0]     limit_q;
  logic [SUM_W-1:0]       wait_sum_q;
  logic [CNT_W-1:0]       long_q;
  logic [CNT_W-1:0]       jobs_q;
  logic                   m_valid_q;
  out_tdata_t             out_q;
  logic                   rd_vld_q;

  logic [TIME_BITS-1:0]   arrival_q;
  logic [TIME_BITS-1:0]   service_q;
  logic [IW-1:0]          last_idx_q;
  logic [IW-1:0]          rd_addr_q;
  logic [IW-1:0]          rd_tag_q;
  logic [TIME_BITS-1:0]   rd_data_q;
  logic [IW-1:0]          best_q;
  logic [TIME_BITS-1:0]   best_val_q;
  logic [TIME_BITS-1:0]   wait_q;

  logic [TIME_BITS-1:0]   free_mem [MAX_SERVERS];

  in_tdata_t              req;
  logic                   in_accept;
  logic [XW-1:0]          arrival_x;
  logic [TIME_BITS-1:0]   arrival_d;
  logic [EW-1:0]          active_x;
  logic [EW-1:0]          n_x;
  logic [IW-1:0]          last_idx_d;
  logic [TIME_BITS-1:0]   rd_val;
  logic                   take;
  logic                   busy;
  logic [TIME_BITS-1:0]   base;
  logic [TIME_BITS:0]     free_sum;
  logic [TIME_BITS-1:0]   new_free;
  logic [TIME_BITS-1:0]   wait_d;
  logic [XW-1:0]          wait_x;
  logic [AW-1:0]          sum_x;
  logic [SUM_W-1:0]       sum_next;
  logic                   long_hit;
  logic [CNT_W-1:0]       long_next;
  logic [CNT_W-1:0]       jobs_next;
  logic [WAIT_W-1:0]      job_wait;
  logic [IW+SERVER_W-1:0] best_ext;
  logic                   out_free;
  logic                   cfg_write;

  assign req           = in_tdata_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == StIdle);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_write     = cfg_valid_i & cfg_ready_o;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;
  assign out_free      = !m_valid_q || m_axis_tready;

  always_comb begin
    arrival_x = XW'(req.arrival_time);
    if (arrival_x > TIME_MAX_X) begin
      arrival_x = TIME_MAX_X;
    end
    arrival_d = TIME_BITS'(arrival_x);
  end

  always_comb begin
    active_x = EW'(active_q);
    if (active_x == '0) begin
      n_x = EW'(1);
    end else if (active_x > MAX_SRV_X) begin
      n_x = MAX_SRV_X;
    end else begin
      n_x = active_x;
    end
    last_idx_d = IW'(n_x - EW'(1));
  end

  assign rd_val = valid_q[rd_tag_q] ? rd_data_q : '0;
  assign take   = rd_vld_q && ((rd_tag_q == '0) || (rd_val < best_val_q));

  always_comb begin
    busy     = best_val_q > arrival_q;
    base     = busy ? best_val_q : arrival_q;
    free_sum = {1'b0, base} + {1'b0, service_q};
    new_free = free_sum[TIME_BITS] ? '1 : free_sum[TIME_BITS-1:0];
    wait_d   = busy ? (best_val_q - arrival_q) : '0;
  end

  always_comb begin
    wait_x    = XW'(wait_q);
    sum_x     = AW'(wait_sum_q) + AW'(wait_q);
    sum_next  = (sum_x > SUM_MAX_X) ? '1 : SUM_W'(sum_x);
    long_hit  = wait_x > XW'(limit_q);
    long_next = (long_hit && (long_q != '1)) ? (long_q + CNT_W'(1)) : long_q;
    jobs_next = (jobs_q != '1) ? (jobs_q + CNT_W'(1)) : jobs_q;
    job_wait  = (wait_x > WAIT_MAX_X) ? '1 : WAIT_W'(wait_x);
    best_ext  = (IW + SERVER_W)'(best_q);
  end

  // Free-time memory: one read or one write per cycle, registered read.
  always_ff @(posedge clk_i) begin
    if (state_q == StScan) begin
      rd_data_q <= free_mem[rd_addr_q];
    end
    if (state_q == StUpdate) begin
      free_mem[best_q] <= new_free;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      arrival_q  <= arrival_d;
      service_q  <= TIME_BITS'(XW'(req.service_time) > TIME_MAX_X ?
                               TIME_MAX_X : XW'(req.service_time));
      last_idx_q <= last_idx_d;
      rd_addr_q  <= '0;
    end else if (state_q == StScan) begin
      rd_addr_q <= rd_addr_q + IW'(1);
    end
    if (state_q == StScan) begin
      rd_tag_q <= rd_addr_q;
    end
    if (take) begin
      best_q     <= rd_tag_q;
      best_val_q <= rd_val;
    end
    if (state_q == StUpdate) begin
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      valid_q    <= '0;
      active_q   <= ACTIVE_RST;
      limit_q    <= LIMIT_RST;
      wait_sum_q <= '0;
      long_q     <= '0;
      jobs_q     <= '0;
      m_valid_q  <= 1'b0;
      out_q      <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgActiveServers: active_q <= cfg_data_i[ACTIVE_W-1:0];
          CfgLongWaitLimit: limit_q  <= cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && (state_q != StDone)) begin
        m_valid_q <= 1'b0;
      end
      rd_vld_q <= (state_q == StScan);
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            if (s_axis_tuser) begin
              valid_q    <= '0;
              wait_sum_q <= '0;
              long_q     <= '0;
              jobs_q     <= '0;
            end
            state_q <= StScan;
          end
        end
        StScan: begin
          if (rd_addr_q == last_idx_q) begin
            state_q <= StDrain;
          end
        end
        StDrain: begin
          state_q <= StUpdate;
        end
        StUpdate: begin
          valid_q[best_q] <= 1'b1;
          state_q         <= StDone;
        end
        StDone: begin
          if (out_free) begin
            wait_sum_q          <= sum_next;
            long_q              <= long_next;
            jobs_q              <= jobs_next;
            out_q.pad           <= '0;
            out_q.job_wait      <= job_wait;
            out_q.chosen_server <= best_ext[SERVER_W-1:0];
            out_q.total_wait    <= sum_next;
            out_q.long_wait_jobs <= long_next;
            out_q.jobs_seen     <= jobs_next;
            m_valid_q           <= 1'b1;
            state_q             <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

// ===== sv/efsq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efsq_checker
// Port-level checks on the earliest free server queue, bound to the top.
// ----------------------------------------------------------------------------
`include "earliest_free_server_queue_top_macros.svh"

module efsq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [efsq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import efsq_pkg::*;

  out_tdata_t res;

  assign res = out_tdata_t'(m_axis_tdata);

  `EFSQ_ASSERT_NXT(a_one_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")
  `EFSQ_ASSERT_IMP(a_jobs_counted, m_axis_tvalid, res.jobs_seen != '0, "result with zero job count")
  `EFSQ_ASSERT_IMP(a_long_bounded, m_axis_tvalid, res.long_wait_jobs <= res.jobs_seen, "long waits exceed jobs")
  `EFSQ_ASSERT_IMP(a_wait_summed, m_axis_tvalid && (res.job_wait != '0), res.total_wait != '0, "wait missing from total")
  `EFSQ_ASSERT_NXT(a_hold_result, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind earliest_free_server_queue_top efsq_checker u_efsq_checker (.*);

// ===== sim/tb_earliest_free_server_queue_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_earliest_free_server_queue_top
// Self-checking bench for the earliest free server queue. A scheduler model
// in this file tracks server free times, wait total and job counts, and
// every output result is compared field by field with it or a pinned value.
// Traffic: a directed table (reset values, extreme times, clamped server
// counts, batch restarts), random job streams under several register
// settings and backpressure mixes, and a closing run on one server held at
// the top of time, where every wait after the first is maximal.
// ----------------------------------------------------------------------------
module tb_earliest_free_server_queue_top;
  import efsq_pkg::*;

  localparam int unsigned SERVERS        = 8;
  localparam logic [23:0] TIME_TOP       = 24'hFFFFFF;
  localparam int          SETTLE_CYCLES  = 16;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          SEGMENTS       = 8;
  localparam int          SEGMENT_JOBS   = 200;
  localparam int          MAX_WAIT_JOBS  = 40;

  typedef enum logic {RowJob, RowCfg} row_kind_e;

  // config rows: arrival holds the active server count, service the limit
  typedef struct packed {
    row_kind_e   kind;
    logic [23:0] arrival;
    logic [23:0] service;
    logic        start;
    logic        pinned;
    logic [23:0] job_wait;
    logic [2:0]  server;
  } plan_row_t;

  localparam int DIRECTED_N = 26;
  localparam plan_row_t DIRECTED [DIRECTED_N] = '{
    '{RowJob, 24'd0,     24'd0,     1'b0, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd0,     TIME_TOP,  1'b0, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd0,     24'd5,     1'b0, 1'b1, TIME_TOP,  3'd0},
    '{RowJob, TIME_TOP,  TIME_TOP,  1'b0, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd100,   24'd3,     1'b1, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd100,   24'd1,     1'b0, 1'b1, 24'd3,     3'd0},
    '{RowJob, 24'd90,    24'd1,     1'b0, 1'b1, 24'd14,    3'd0},
    '{RowCfg, 24'd0,     24'd0,     1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, 24'd0,     24'd1,     1'b1, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd0,     24'd1,     1'b0, 1'b1, 24'd1,     3'd0},
    '{RowCfg, 24'd8,     TIME_TOP,  1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, 24'd10,    24'd10,    1'b1, 1'b1, 24'd0,     3'd0},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd1},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd2},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd3},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd4},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd5},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd6},
    '{RowJob, 24'd10,    24'd10,    1'b0, 1'b1, 24'd0,     3'd7},
    '{RowJob, 24'd10,    24'd1,     1'b0, 1'b1, 24'd10,    3'd0},
    '{RowCfg, 24'd15,    24'd5,     1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, 24'd0,     24'd7,     1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, TIME_TOP,  TIME_TOP,  1'b0, 1'b0, 24'd0,     3'd0},
    '{RowCfg, 24'd3,     24'd2,     1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, 24'd5,     24'd2,     1'b0, 1'b0, 24'd0,     3'd0},
    '{RowJob, TIME_TOP,  24'd0,     1'b1, 1'b1, 24'd0,     3'd0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // expectation override for directed rows, travels with the request
  logic        pin_on     = 1'b0;
  logic [23:0] pin_wait   = '0;
  logic [2:0]  pin_server = '0;

  // scheduler model state
  logic [23:0]         free_at [SERVERS];
  logic [SUM_W-1:0]    wait_total  = '0;
  logic [CNT_W-1:0]    long_jobs   = '0;
  logic [CNT_W-1:0]    job_total   = '0;
  logic [ACTIVE_W-1:0] active_cfg  = ACTIVE_RST;
  logic [LIMIT_W-1:0]  limit_cfg   = LIMIT_RST;

  out_tdata_t pending_results [$];

  int mismatches      = 0;
  int results_checked = 0;
  int delayed_jobs    = 0;
  int long_jobs_seen  = 0;
  int jobs_sent       = 0;
  int cfg_settings    = 0;
  int stalled_cycles  = 0;
  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int hold_ticket     = 0;
  int hold_served     = 0;
  int hold_left       = 0;

  earliest_free_server_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int k = 0; k < SERVERS; k++) free_at[k] = '0;
  end

  function automatic out_tdata_t serve_job(input logic [23:0] arrival,
                                           input logic [23:0] service,
                                           input logic start);
    int unsigned n;
    int unsigned best;
    logic [24:0] finish;
    logic [23:0] delay;
    logic [SUM_W:0] acc;
    out_tdata_t r;
    if (start) begin
      for (int k = 0; k < SERVERS; k++) free_at[k] = '0;
      wait_total = '0;
      long_jobs  = '0;
      job_total  = '0;
    end
    n = active_cfg;
    if (n < 1) n = 1;
    if (n > SERVERS) n = SERVERS;
    best = 0;
    for (int k = 1; k < n; k++)
      if (free_at[k] < free_at[best]) best = k;
    if (free_at[best] <= arrival) begin
      delay  = '0;
      finish = {1'b0, arrival} + {1'b0, service};
    end else begin
      delay  = free_at[best] - arrival;
      finish = {1'b0, free_at[best]} + {1'b0, service};
    end
    free_at[best] = finish[24] ? TIME_TOP : finish[23:0];
    acc = {1'b0, wait_total} + {{(SUM_W - 23){1'b0}}, delay};
    wait_total = acc[SUM_W] ? '1 : acc[SUM_W-1:0];
    if (delay > limit_cfg && long_jobs != '1) long_jobs = long_jobs + 1'b1;
    if (job_total != '1) job_total = job_total + 1'b1;
    r = '0;
    r.job_wait       = delay;
    r.chosen_server  = best[2:0];
    r.total_wait     = wait_total;
    r.long_wait_jobs = long_jobs;
    r.jobs_seen      = job_total;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("[%0t] MISMATCH %s: got %0h, expected %0h (result %0d)",
             $realtime, what, got, want, results_checked);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] raw);
    out_tdata_t got;
    out_tdata_t want;
    got = raw;
    if (pending_results.size() == 0) begin
      report_mismatch("result with no request pending", 64'(raw), 64'd0);
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    if (want.job_wait != '0) delayed_jobs++;
    if (got.job_wait !== want.job_wait)
      report_mismatch("job_wait", 64'(got.job_wait), 64'(want.job_wait));
    if (got.chosen_server !== want.chosen_server)
      report_mismatch("chosen_server", 64'(got.chosen_server), 64'(want.chosen_server));
    if (got.total_wait !== want.total_wait)
      report_mismatch("total_wait", 64'(got.total_wait), 64'(want.total_wait));
    if (got.long_wait_jobs !== want.long_wait_jobs)
      report_mismatch("long_wait_jobs", 64'(got.long_wait_jobs),
                      64'(want.long_wait_jobs));
    if (got.jobs_seen !== want.jobs_seen)
      report_mismatch("jobs_seen", 64'(got.jobs_seen), 64'(want.jobs_seen));
    if (got.pad !== '0)
      report_mismatch("tdata padding", 64'(got.pad), 64'd0);
  endtask

  always @(posedge clk_i) begin : job_monitor
    out_tdata_t predicted;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgActiveServers: active_cfg = cfg_data_i[ACTIVE_W-1:0];
          CfgLongWaitLimit: limit_cfg  = cfg_data_i[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = serve_job(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tuser);
        if (predicted.job_wait > limit_cfg) long_jobs_seen++;
        if (pin_on) begin
          predicted.job_wait      = pin_wait;
          predicted.chosen_server = pin_server;
        end
        pending_results.push_back(predicted);
      end
    end
  end

  // hold off completely on request, else stall at random
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_served != hold_ticket) begin
      hold_served   <= hold_ticket;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stalled_cycles <= 0;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] TIMEOUT: no handshake for %0d cycles, %0d results pending",
                 $realtime, stalled_cycles, pending_results.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_job(input logic [23:0] arrival, input logic [23:0] service,
                          input logic start, input logic pinned,
                          input logic [23:0] pw, input logic [2:0] ps);
    s_axis_tdata  <= {service, arrival};
    s_axis_tuser  <= start;
    s_axis_tvalid <= 1'b1;
    pin_on        <= pinned;
    pin_wait      <= pw;
    pin_server    <= ps;
    do @(posedge clk_i); while (!s_axis_tready);
    jobs_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [ACTIVE_W-1:0] active,
                            input logic [LIMIT_W-1:0] limit);
    cfg_index_i <= CfgActiveServers;
    cfg_data_i  <= CFG_DATA_W'(active);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgLongWaitLimit;
    cfg_data_i  <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_settings++;
  endtask

  initial begin : stimulus
    plan_row_t           row;
    logic [ACTIVE_W-1:0] act;
    logic [LIMIT_W-1:0]  lim;
    logic [23:0]         arrival;
    logic [23:0]         service;
    logic [23:0]         clock_now;
    logic                start;
    int unsigned         eff;
    int                  r;
    int                  inc;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_N; i++) begin
      row = DIRECTED[i];
      if (row.kind == RowCfg) begin
        drain_results();
        set_config(row.arrival[ACTIVE_W-1:0], row.service);
      end else begin
        send_job(row.arrival, row.service, row.start, row.pinned, row.job_wait,
                 row.server);
      end
    end

    clock_now = '0;
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain_results();
      case (seg)
        0: begin act = 4'd1; lim = '0; end
        1: begin act = 4'd8; lim = TIME_TOP; end
        2: begin act = 4'd0; lim = 24'd10; end
        3: begin act = 4'd15; lim = 24'($urandom_range(0, 50)); end
        4: begin act = 4'($urandom_range(2, 7)); lim = 24'($urandom_range(0, 200)); end
        5: begin act = 4'($urandom_range(9, 14)); lim = 24'($urandom()); end
        6: begin act = 4'd1; lim = 24'($urandom_range(0, 1000)); end
        default: begin
          act = 4'($urandom_range(0, 15));
          lim = 24'($urandom_range(0, 30));
        end
      endcase
      set_config(act, lim);
      eff = (act == 0) ? 1 : (act > SERVERS) ? SERVERS : act;
      case (seg % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 46; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 46; end
        default: begin tx_idle_pct = 27; rx_stall_pct <= 27; end
      endcase
      if (seg == 0) hold_ticket <= hold_ticket + 1;
      for (int k = 0; k < SEGMENT_JOBS; k++) begin
        r = $urandom_range(99);
        if (r < 70) begin
          // steady arrivals near full load
          inc     = $urandom_range(0, 24);
          service = 24'($urandom_range(0, 20 * eff + 10));
          start   = ($urandom_range(63) == 0);
          if (clock_now > TIME_TOP - 24'd100) begin
            start     = 1'b1;
            clock_now = 24'(inc);
          end else begin
            clock_now = clock_now + 24'(inc);
          end
          arrival = clock_now;
        end else if (r < 85) begin
          arrival = 24'($urandom());
          service = 24'($urandom());
          start   = 1'($urandom_range(1));
        end else if (r < 95) begin
          arrival = TIME_TOP - 24'($urandom_range(0, 50));
          service = 24'($urandom());
          start   = 1'b0;
        end else begin
          arrival   = 24'($urandom_range(0, 1000));
          service   = 24'($urandom_range(0, 100));
          start     = 1'b1;
          clock_now = arrival;
        end
        send_job(arrival, service, start, 1'b0, '0, '0);
      end
    end

    // single server pinned at the top of time: every later wait is maximal
    drain_results();
    set_config(4'd1, 24'd10);
    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    send_job(24'd0, TIME_TOP, 1'b1, 1'b0, '0, '0);
    for (int k = 0; k < MAX_WAIT_JOBS; k++)
      send_job(24'd0, 24'($urandom()), 1'b0, 1'b0, '0, '0);

    drain_results();
    $display("Covered %0d jobs over %0d register settings, %0d results checked",
             jobs_sent, cfg_settings, results_checked);
    $display("Of these %0d waited and %0d were long waits, under mixed backpressure",
             delayed_jobs, long_jobs_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
